/* design/siv_pkg.sv */
// ----------------------------------------------------------------------------
// Flash image verifier package
// Shared types, register indexes, header constants and the FNV-1a 64 step.
// ----------------------------------------------------------------------------
package siv_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;

  // Expected section lengths are carried at this width.
  localparam int unsigned LEN_BITS = 48;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FORMAT_KIND      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_BYTES       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_BYTES      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGES_EACH_BLOCK = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCKS_TOTAL     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOR_BYTES        = 3'd5;

  // Image header constants.
  localparam logic [31:0] NAND_MAGIC    = 32'h334f_4956;
  localparam logic [31:0] NOR_MAGIC     = 32'h524f_4e56;
  localparam logic [31:0] IMAGE_VERSION = 32'd1;
  localparam logic [31:0] FLAG_HASHED   = 32'd1;

  // FNV-1a 64 constants.
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

  // Verdict reported with each image.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FORMAT    = 3'd1,
    ST_VERSION   = 3'd2,
    ST_GEOMETRY  = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_CHECKSUM  = 3'd5,
    ST_TRAILING  = 3'd6
  } status_e;

  // One FNV-1a 64 step. The prime is 2^40 + 2^8 + 0xb3, so the product is a
  // short sum of shifted copies.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* design/siv_if.sv */
// ----------------------------------------------------------------------------
// Flash image verifier channels
// Valid/ready channels for image bytes, results and configuration writes.
// ----------------------------------------------------------------------------

// Image byte channel.
interface siv_byte_if import siv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel, one word per image.
interface siv_result_if import siv_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] computed_hash;

  modport source (output valid, output status, output computed_hash, input ready);
  modport sink   (input valid, input status, input computed_hash, output ready);
endinterface

// Configuration write channel.
interface siv_cfg_if import siv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  value;

  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

/* design/storage_image_verifier.sv */
// ----------------------------------------------------------------------------
// Flash image verifier
// Checks a NAND or NOR image file streamed one byte per word and reports one
// status and the FNV-1a 64 payload hash at the byte marked last.
// ----------------------------------------------------------------------------
// The block takes one image byte every clock cycle while byte ready is high.
// Header checks, the hash step and the section counters are combinational,
// and the status word of an image is registered at its last byte into the
// output register, or into a one-word skid stage while the output register
// holds an untaken word. A stalled result sink stops the byte stream only
// when both hold a word. The expected NAND payload length comes from two
// registered multiplies over the geometry registers: after reset and after
// every configuration write, byte ready is held low while these products settle.
module storage_image_verifier import siv_pkg::*; #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  siv_cfg_if.sink    cfg_i,
  siv_byte_if.sink   byte_i,
  siv_result_if.source result_o
);

  // Phase codes.
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PAYLOAD = 3'd1;
  localparam logic [2:0] PH_TRAILER = 3'd2;
  localparam logic [2:0] PH_END     = 3'd3;
  localparam logic [2:0] PH_EXCESS  = 3'd4;
  localparam logic [2:0] PH_FAULT   = 3'd5;

  localparam logic [1:0] RECALC_CYCLES = 2'd3;

  // Configuration registers.
  logic        fmt_q;
  logic [15:0] page_q;
  logic [11:0] spare_q;
  logic [12:0] ppb_q;
  logic [16:0] blocks_q;
  logic [26:0] nor_q;

  // Length products.
  logic [29:0]         pages_q;
  logic [16:0]         psum_q;
  logic [LEN_BITS-1:0] marks_q;
  logic [LEN_BITS-1:0] plen_q;
  logic [1:0]          recalc_q;

  // Image state.
  logic [2:0]               phase_q, phase_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_inc;
  logic [31:0]              wg_q, wg_d;
  status_e                  verdict_q, verdict_d;
  logic                     trl_q, trl_d;
  logic [63:0]              hash_q, hash_d;
  logic [63:0]              tg_q, tg_d;
  logic                     bad_q, bad_d;

  // Result side.
  logic        out_valid_q, skid_valid_q;
  status_e     out_status_q, skid_status_q;
  logic [63:0] out_hash_q, skid_hash_q;
  logic        res_new;
  status_e     res_status;
  logic [63:0] res_hash;

  logic                byte_fire, out_fire;
  logic [LEN_BITS-1:0] pay_len;
  logic [LEN_BITS-1:0] pos_ext, pos_inc_ext;
  logic [5:0]          hdr_len;
  logic [2:0]          word_idx;
  logic [31:0]         wg_new;
  status_e             code;
  status_e             end_st;

  assign cfg_i.ready  = 1'b1;
  assign byte_i.ready = (recalc_q == 2'd0) && !skid_valid_q;
  assign byte_fire    = byte_i.valid && byte_i.ready;
  assign out_fire     = out_valid_q && result_o.ready;

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = out_status_q;
  assign result_o.computed_hash = out_hash_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= 1'b0;
      page_q   <= 16'd2048;
      spare_q  <= 12'd64;
      ppb_q    <= 13'd64;
      blocks_q <= 17'd4096;
      nor_q    <= 27'd1048576;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_FORMAT_KIND:      fmt_q    <= cfg_i.value[0];
        REG_PAGE_BYTES:       page_q   <= cfg_i.value[15:0];
        REG_SPARE_BYTES:      spare_q  <= cfg_i.value[11:0];
        REG_PAGES_EACH_BLOCK: ppb_q    <= cfg_i.value[12:0];
        REG_BLOCKS_TOTAL:     blocks_q <= cfg_i.value[16:0];
        REG_NOR_BYTES:        nor_q    <= cfg_i.value[26:0];
        default: ;
      endcase
    end
  end

  // Hold off bytes while the length products settle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recalc_q <= RECALC_CYCLES;
    end else if (cfg_i.valid && cfg_i.ready) begin
      recalc_q <= RECALC_CYCLES;
    end else if (recalc_q != 2'd0) begin
      recalc_q <= recalc_q - 2'd1;
    end
  end

  // Bad-block marks start after all pages; the marks follow, one per block.
  always_ff @(posedge clk_i) begin
    pages_q <= 30'(ppb_q) * 30'(blocks_q);
    psum_q  <= 17'(page_q) + 17'(spare_q);
    marks_q <= LEN_BITS'(47'(pages_q) * 47'(psum_q));
    plen_q  <= marks_q + LEN_BITS'(blocks_q);
  end

  assign pay_len     = fmt_q ? LEN_BITS'(nor_q) : plen_q;
  assign hdr_len     = fmt_q ? 6'd16 : 6'd32;
  assign pos_inc     = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign pos_ext     = LEN_BITS'(pos_q);
  assign pos_inc_ext = LEN_BITS'(pos_inc);
  assign word_idx    = pos_inc[4:2] - 3'd1;
  assign wg_new      = {byte_i.data_byte, wg_q[31:8]};

  // Header word check, valid when a whole word has been gathered.
  always_comb begin
    code = ST_OK;
    if (!fmt_q) begin
      case (word_idx)
        3'd0: if (wg_new != NAND_MAGIC) code = ST_FORMAT;
        3'd1: if (wg_new != IMAGE_VERSION) code = ST_VERSION;
        3'd2: if (wg_new != 32'(page_q)) code = ST_GEOMETRY;
        3'd3: if (wg_new != 32'(spare_q)) code = ST_GEOMETRY;
        3'd4: if (wg_new != 32'(ppb_q)) code = ST_GEOMETRY;
        3'd5: if (wg_new != 32'(blocks_q)) code = ST_GEOMETRY;
        3'd6: if ((wg_new & ~FLAG_HASHED) != 32'd0) code = ST_TRAILING;
        default: if (wg_new != 32'd0) code = ST_TRAILING;
      endcase
    end else begin
      case (word_idx)
        3'd0: if (wg_new != NOR_MAGIC) code = ST_FORMAT;
        3'd1: if (wg_new != IMAGE_VERSION) code = ST_VERSION;
        3'd2: if (wg_new != 32'(nor_q)) code = ST_GEOMETRY;
        3'd3: if ((wg_new & ~FLAG_HASHED) != 32'd0) code = ST_TRAILING;
        default: ;
      endcase
    end
  end

  // Per-byte state update.
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    wg_d       = wg_q;
    verdict_d  = verdict_q;
    trl_d      = trl_q;
    hash_d     = hash_q;
    tg_d       = tg_q;
    bad_d      = bad_q;
    res_new    = 1'b0;
    res_status = ST_OK;
    res_hash   = hash_q;
    end_st     = ST_OK;

    if (byte_fire) begin
      case (phase_q)
        PH_HEADER: begin
          wg_d  = wg_new;
          pos_d = pos_inc;
          if (pos_inc[1:0] == 2'd0) begin
            // The flag word also sets whether a trailer follows.
            if ((!fmt_q && word_idx == 3'd6) || (fmt_q && word_idx == 3'd3)) begin
              trl_d = wg_new[0];
            end
            if (code != ST_OK && (verdict_q == ST_OK ||
                (!fmt_q && code == ST_TRAILING && verdict_q == ST_GEOMETRY))) begin
              verdict_d = code;
            end
          end
          if (pos_inc >= POSITION_BITS'(hdr_len)) begin
            if (verdict_d != ST_OK) begin
              phase_d = PH_FAULT;
            end else begin
              pos_d = '0;
              if (pay_len == '0) begin
                phase_d = trl_d ? PH_TRAILER : PH_END;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          hash_d = fnv_step(hash_q, byte_i.data_byte);
          if (!fmt_q && pos_ext >= marks_q && byte_i.data_byte > 8'd1) begin
            bad_d = 1'b1;
          end
          pos_d = pos_inc;
          if (pos_inc_ext >= pay_len) begin
            pos_d   = '0;
            phase_d = trl_q ? PH_TRAILER : PH_END;
          end
        end
        PH_TRAILER: begin
          tg_d  = {byte_i.data_byte, tg_q[63:8]};
          pos_d = pos_inc;
          if (pos_inc >= POSITION_BITS'(8)) begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          phase_d = PH_EXCESS;
        end
        default: ;
      endcase

      // The last byte closes the image and starts a fresh one.
      if (byte_i.last_byte) begin
        // End verdict: hash mismatch, then a bad mark, then bytes past the end.
        if (trl_d && (tg_d != hash_d)) begin
          end_st = ST_CHECKSUM;
        end else if (bad_d) begin
          end_st = ST_FORMAT;
        end else if (phase_d == PH_EXCESS) begin
          end_st = ST_TRAILING;
        end else begin
          end_st = ST_OK;
        end
        res_new  = 1'b1;
        res_hash = hash_d;
        case (phase_d)
          PH_FAULT:  res_status = verdict_d;
          PH_END:    res_status = end_st;
          PH_EXCESS: res_status = end_st;
          default:   res_status = ST_TRUNCATED;
        endcase
        phase_d   = PH_HEADER;
        pos_d     = '0;
        wg_d      = '0;
        verdict_d = ST_OK;
        trl_d     = 1'b0;
        hash_d    = FNV_BASIS;
        tg_d      = '0;
        bad_d     = 1'b0;
      end
    end
  end

  // Image state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      wg_q      <= '0;
      verdict_q <= ST_OK;
      trl_q     <= 1'b0;
      hash_q    <= FNV_BASIS;
      tg_q      <= '0;
      bad_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      wg_q      <= wg_d;
      verdict_q <= verdict_d;
      trl_q     <= trl_d;
      hash_q    <= hash_d;
      tg_q      <= tg_d;
      bad_q     <= bad_d;
    end
  end

  // Result valid flags: output register first, skid word behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_new) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_status_q <= skid_status_q;
        out_hash_q   <= skid_hash_q;
      end
    end else if (res_new) begin
      if (out_valid_q && !out_fire) begin
        skid_status_q <= res_status;
        skid_hash_q   <= res_hash;
      end else begin
        out_status_q <= res_status;
        out_hash_q   <= res_hash;
      end
    end
  end

endmodule

/* design/siv_checker.sv */
// ----------------------------------------------------------------------------
// Flash image verifier checker
// Port-level assertions on the verifier, bound to the top level.
// ----------------------------------------------------------------------------
module siv_checker import siv_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       byte_valid,
  input logic       byte_ready,
  input logic       byte_last,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] res_status,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // A stalled result word holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_status))
    else $error("result word dropped or changed while stalled");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_status <= 3'd6)
    else $error("undefined status code");

  // A configuration write holds off the byte stream while lengths settle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready |=> !byte_ready)
    else $error("byte accepted before lengths settled");

  // Only a last byte produces a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid && byte_valid && byte_ready && !byte_last |=> !res_valid)
    else $error("result word without a last byte");

endmodule

bind storage_image_verifier siv_checker u_siv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .byte_valid (byte_i.valid),
  .byte_ready (byte_i.ready),
  .byte_last  (byte_i.last_byte),
  .res_valid  (result_o.valid),
  .res_ready  (result_o.ready),
  .res_status (result_o.status),
  .cfg_valid  (cfg_i.valid),
  .cfg_ready  (cfg_i.ready)
);

/* tb/storage_image_verifier_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flash image verifier checker
// Watches the configuration, byte and result channels of the verifier. It
// keeps its own model of the image parser, queues one expected status word
// per image and compares every result word against the oldest one.
// ----------------------------------------------------------------------------
module storage_image_verifier_checker import siv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  siv_cfg_if    cfg_i,
  siv_byte_if   byte_i,
  siv_result_if result_i,
  output int    fail_count_o,
  output int    pending_o
);

  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [47:0] POS_TOP   = '1;

  // Where the parser stands within the current image.
  typedef enum logic [2:0] {
    SEC_HEADER,
    SEC_PAYLOAD,
    SEC_TRAILER,
    SEC_END,
    SEC_EXCESS,
    SEC_FAULT
  } section_e;

  typedef struct packed {
    status_e     status;
    logic [63:0] hash;
  } image_verdict_t;

  // Copy of the geometry registers.
  logic        is_nor;
  logic [15:0] page_bytes;
  logic [11:0] spare_bytes;
  logic [12:0] pages_each_block;
  logic [16:0] blocks_total;
  logic [26:0] nor_bytes;

  // Per-image parser state.
  section_e    section;
  logic [47:0] pos;
  logic [31:0] word_acc;
  status_e     hdr_verdict;
  logic        hashed;
  logic [63:0] payload_hash;
  logic [63:0] trailer_acc;
  logic        bad_mark;

  image_verdict_t verdict_q[$];
  image_verdict_t want;
  int             fail_count;

  function automatic void start_image();
    section      = SEC_HEADER;
    pos          = '0;
    word_acc     = '0;
    hdr_verdict  = ST_OK;
    hashed       = 1'b0;
    payload_hash = FNV_BASIS;
    trailer_acc  = '0;
    bad_mark     = 1'b0;
  endfunction

  // Byte offset of the first bad-block mark within a NAND payload.
  function automatic logic [63:0] marks_offset();
    logic [63:0] pages;
    pages = pages_each_block * blocks_total;
    return pages * page_bytes + pages * spare_bytes;
  endfunction

  function automatic logic [63:0] body_len();
    logic [63:0] len;
    if (is_nor) begin
      len = nor_bytes;
    end else begin
      len = marks_offset() + blocks_total;
    end
    return len;
  endfunction

  // The section counter saturates instead of wrapping.
  function automatic void advance();
    if (pos != POS_TOP) begin
      pos = pos + 48'd1;
    end
  endfunction

  function automatic void close_body();
    pos     = '0;
    section = hashed ? SEC_TRAILER : SEC_END;
  endfunction

  // Feed one image byte; on the last byte queue the expected status word.
  function automatic void absorb(input logic [7:0] b, input logic is_last);
    status_e     code;
    status_e     st;
    logic [47:0] idx;
    code = ST_OK;
    st   = ST_OK;
    case (section)
      SEC_HEADER: begin
        word_acc = {b, word_acc[31:8]};
        advance();
        if (pos[1:0] == 2'd0) begin
          idx = (pos >> 2) - 48'd1;
          if (!is_nor) begin
            case (idx)
              0: if (word_acc != NAND_MAGIC) code = ST_FORMAT;
              1: if (word_acc != IMAGE_VERSION) code = ST_VERSION;
              2: if (word_acc != {16'd0, page_bytes}) code = ST_GEOMETRY;
              3: if (word_acc != {20'd0, spare_bytes}) code = ST_GEOMETRY;
              4: if (word_acc != {19'd0, pages_each_block}) code = ST_GEOMETRY;
              5: if (word_acc != {15'd0, blocks_total}) code = ST_GEOMETRY;
              6: begin
                hashed = |(word_acc & FLAG_HASHED);
                if ((word_acc & ~FLAG_HASHED) != 0) code = ST_TRAILING;
              end
              7: if (word_acc != 0) code = ST_TRAILING;
              default: ;
            endcase
          end else begin
            case (idx)
              0: if (word_acc != NOR_MAGIC) code = ST_FORMAT;
              1: if (word_acc != IMAGE_VERSION) code = ST_VERSION;
              2: if (word_acc != {5'd0, nor_bytes}) code = ST_GEOMETRY;
              3: begin
                hashed = |(word_acc & FLAG_HASHED);
                if ((word_acc & ~FLAG_HASHED) != 0) code = ST_TRAILING;
              end
              default: ;
            endcase
          end
          // First fault wins, except that on NAND a flag or reserved fault
          // outranks a geometry fault seen earlier in the header.
          if (code != ST_OK && (hdr_verdict == ST_OK ||
              (!is_nor && code == ST_TRAILING && hdr_verdict == ST_GEOMETRY))) begin
            hdr_verdict = code;
          end
        end
        if (pos >= (is_nor ? 48'd16 : 48'd32)) begin
          if (hdr_verdict != ST_OK) begin
            section = SEC_FAULT;
          end else begin
            section = SEC_PAYLOAD;
            pos     = '0;
            if (body_len() == 0) close_body();
          end
        end
      end
      SEC_PAYLOAD: begin
        payload_hash = (payload_hash ^ {56'd0, b}) * FNV_PRIME;
        if (!is_nor && {16'd0, pos} >= marks_offset() && b > 8'd1) bad_mark = 1'b1;
        advance();
        if ({16'd0, pos} >= body_len()) close_body();
      end
      SEC_TRAILER: begin
        trailer_acc = {b, trailer_acc[63:8]};
        advance();
        if (pos >= 48'd8) section = SEC_END;
      end
      SEC_END: section = SEC_EXCESS;
      default: ;
    endcase

    if (is_last) begin
      case (section)
        SEC_FAULT: st = hdr_verdict;
        SEC_END, SEC_EXCESS: begin
          if (hashed && trailer_acc != payload_hash) st = ST_CHECKSUM;
          else if (bad_mark) st = ST_FORMAT;
          else if (section == SEC_EXCESS) st = ST_TRAILING;
          else st = ST_OK;
        end
        default: st = ST_TRUNCATED;
      endcase
      verdict_q.push_back('{status: st, hash: payload_hash});
      start_image();
    end
  endfunction

  // Results are checked before the byte of the same edge is folded in, so a
  // status word can never match an image that ended in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_nor           = 1'b0;
      page_bytes       = 16'd2048;
      spare_bytes      = 12'd64;
      pages_each_block = 13'd64;
      blocks_total     = 17'd4096;
      nor_bytes        = 27'd1048576;
      start_image();
      verdict_q.delete();
      fail_count       = 0;
      fail_count_o    <= 0;
      pending_o       <= 0;
    end else begin
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: status word with no image pending: status %0d hash %h",
                     $realtime, result_i.status, result_i.computed_hash);
          end
        end else begin
          want = verdict_q.pop_front();
          if (result_i.status !== want.status || result_i.computed_hash !== want.hash) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: status word mismatch: expected status %0d hash %h",
                       $realtime, want.status, want.hash);
              $display("%0t:                      got      status %0d hash %h",
                       $realtime, result_i.status, result_i.computed_hash);
            end
          end
        end
      end

      if (cfg_i.valid === 1'b1 && cfg_i.ready === 1'b1) begin
        case (cfg_i.index)
          REG_FORMAT_KIND:      is_nor           = cfg_i.value[0];
          REG_PAGE_BYTES:       page_bytes       = cfg_i.value[15:0];
          REG_SPARE_BYTES:      spare_bytes      = cfg_i.value[11:0];
          REG_PAGES_EACH_BLOCK: pages_each_block = cfg_i.value[12:0];
          REG_BLOCKS_TOTAL:     blocks_total     = cfg_i.value[16:0];
          REG_NOR_BYTES:        nor_bytes        = cfg_i.value[26:0];
          default: ;
        endcase
      end

      if (byte_i.valid === 1'b1 && byte_i.ready === 1'b1) begin
        absorb(byte_i.data_byte, byte_i.last_byte);
      end

      fail_count_o <= fail_count;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

/* tb/storage_image_verifier_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flash image verifier testbench
// Streams NAND and NOR images through the verifier under several geometry
// settings: directed header, trailer, mark and length cases first, then
// random well-formed and damaged images, with random idling on both sides.
// ----------------------------------------------------------------------------
module storage_image_verifier_tb;
  import siv_pkg::*;

  localparam int          CYCLE_LIMIT = 40000;
  localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int   stall_left;
  int   cycle_count = 0;
  int   mismatch_count;
  int   pending_words;
  int   bytes_sent = 0;

  // Geometry as last written, used to build matching headers.
  logic        cfg_nor;
  logic [15:0] cfg_page;
  logic [11:0] cfg_spare;
  logic [12:0] cfg_ppb;
  logic [16:0] cfg_blocks;
  logic [26:0] cfg_norb;

  // Image under construction, in file order.
  logic [7:0] image_q[$];

  siv_cfg_if    cfg_if ();
  siv_byte_if   byte_if ();
  siv_result_if result_if ();

  storage_image_verifier i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  storage_image_verifier_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .byte_i       (byte_if),
    .result_i     (result_if),
    .fail_count_o (mismatch_count),
    .pending_o    (pending_words)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result sink: stalls in bursts of random length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left      <= 0;
      result_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      result_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left      <= $urandom_range(0, 4);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Send one byte, sometimes after a short gap, and wait for the handshake.
  task automatic put_byte(input logic [7:0] value, input logic is_last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= value;
    byte_if.last_byte <= is_last;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
  endtask

  task automatic send_image();
    int n;
    n = image_q.size();
    for (int k = 0; k < n; k++) begin
      put_byte(image_q[k], k == n - 1);
    end
    bytes_sent += n;
    image_q.delete();
  endtask

  // Wait until every image has reported, then give the block time to go idle.
  task automatic settle();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.value <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
  endtask

  // Rewrite all six registers once the block has drained.
  task automatic configure(input logic is_nor, input int page, spare, ppb, blocks, norb);
    settle();
    cfg_nor    = is_nor;
    cfg_page   = 16'(page);
    cfg_spare  = 12'(spare);
    cfg_ppb    = 13'(ppb);
    cfg_blocks = 17'(blocks);
    cfg_norb   = 27'(norb);
    write_reg(REG_FORMAT_KIND, {31'd0, is_nor});
    write_reg(REG_PAGE_BYTES, page);
    write_reg(REG_SPARE_BYTES, spare);
    write_reg(REG_PAGES_EACH_BLOCK, ppb);
    write_reg(REG_BLOCKS_TOTAL, blocks);
    write_reg(REG_NOR_BYTES, norb);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_setting();
    configure($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 2),
              $urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(0, 20));
  endtask

  function automatic void add_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) begin
      image_q.push_back(w[8*k +: 8]);
    end
  endfunction

  // Header that matches the current geometry.
  function automatic void add_header(input logic [31:0] magic, version, flags);
    add_word(magic);
    add_word(version);
    if (cfg_nor) begin
      add_word({5'd0, cfg_norb});
      add_word(flags);
    end else begin
      add_word({16'd0, cfg_page});
      add_word({20'd0, cfg_spare});
      add_word({19'd0, cfg_ppb});
      add_word({15'd0, cfg_blocks});
      add_word(flags);
      add_word(32'd0);
    end
  endfunction

  // Complete image: header, payload with legal marks unless one is to be bad,
  // and a hash trailer XORed with trailer_flip when the hash flag is set.
  function automatic void build_image(input logic hashed, input logic bad_mark,
                                      input logic [63:0] trailer_flip);
    longint unsigned plen;
    longint unsigned marks_at;
    longint unsigned bad_at;
    logic [63:0]     h;
    logic [7:0]      b;
    add_header(cfg_nor ? NOR_MAGIC : NAND_MAGIC, IMAGE_VERSION, {31'd0, hashed});
    if (cfg_nor) begin
      plen     = cfg_norb;
      marks_at = plen;
    end else begin
      marks_at = longint'(cfg_ppb) * cfg_blocks * (cfg_page + cfg_spare);
      plen     = marks_at + cfg_blocks;
    end
    bad_at = (bad_mark && !cfg_nor) ? marks_at + $urandom_range(0, cfg_blocks - 1) : plen;
    h = FNV_BASIS;
    for (longint unsigned p = 0; p < plen; p++) begin
      if (p < marks_at) b = 8'($urandom);
      else if (p == bad_at) b = 8'($urandom_range(2, 255));
      else b = 8'($urandom_range(0, 1));
      image_q.push_back(b);
      h = (h ^ {56'd0, b}) * FNV_PRIME;
    end
    if (hashed) begin
      h = h ^ trailer_flip;
      for (int k = 0; k < 8; k++) begin
        image_q.push_back(h[8*k +: 8]);
      end
    end
  endfunction

  // Mostly well-formed images, the rest damaged in one way or pure noise.
  task automatic random_image();
    int kind;
    int cut;
    kind = $urandom_range(0, 15);
    if (kind == 15) begin
      repeat ($urandom_range(1, 40)) image_q.push_back(8'($urandom));
    end else begin
      build_image($urandom_range(0, 1), kind == 10,
                  ($urandom_range(0, 7) == 0) ? 64'd1 << $urandom_range(0, 63) : 64'd0);
      case (kind)
        11: repeat ($urandom_range(1, 3)) image_q.push_back(8'($urandom));
        12: begin
          cut = $urandom_range(1, image_q.size() - 1);
          repeat (cut) void'(image_q.pop_back());
        end
        13: image_q[$urandom_range(0, cfg_nor ? 15 : 31)] ^= 8'd1 << $urandom_range(0, 7);
        14: image_q[(cfg_nor ? 12 : 24) + $urandom_range(0, cfg_nor ? 3 : 7)] = 8'($urandom);
        default: ;
      endcase
    end
    send_image();
  endtask

  initial begin
    int round;
    rst_ni            = 1'b0;
    quiet             = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_FORMAT_KIND;
    cfg_if.value      = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    cfg_nor           = 1'b0;
    cfg_page          = 16'd2048;
    cfg_spare         = 12'd64;
    cfg_ppb           = 13'd64;
    cfg_blocks        = 17'd4096;
    cfg_norb          = 27'd1048576;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry is far too large to stream: a matching header and a few
    // payload bytes end truncated, and so does a header cut short.
    add_header(NAND_MAGIC, IMAGE_VERSION, FLAG_HASHED);
    repeat (4) image_q.push_back(8'($urandom));
    send_image();
    repeat (7) image_q.push_back(8'($urandom));
    send_image();

    // A large geometry on both formats; the images end truncated.
    configure(1'b0, 65535, 4095, 4096, 65536, 67108864);
    add_header(NAND_MAGIC, IMAGE_VERSION, 32'd0);
    repeat (3) image_q.push_back(8'($urandom));
    send_image();
    configure(1'b1, 0, 0, 1, 1, 67108864);
    add_header(NOR_MAGIC, IMAGE_VERSION, FLAG_HASHED);
    repeat (3) image_q.push_back(8'($urandom));
    send_image();

    // Empty NOR payload: header only, basis hash trailer, trailing byte,
    // size fault outranking a flag fault, bad version.
    configure(1'b1, 0, 0, 1, 1, 0);
    build_image(1'b0, 1'b0, 64'd0);
    send_image();
    build_image(1'b1, 1'b0, 64'd0);
    send_image();
    build_image(1'b0, 1'b0, 64'd0);
    image_q.push_back(8'hff);
    send_image();
    build_image(1'b1, 1'b0, 64'd0);
    image_q[8]  ^= 8'h01;
    image_q[12] |= 8'h02;
    send_image();
    build_image(1'b0, 1'b0, 64'd0);
    image_q[4] = 8'h00;
    send_image();

    // NAND image whose payload is one mark byte.
    configure(1'b0, 0, 0, 1, 1, 0);
    build_image(1'b1, 1'b0, 64'd0);
    send_image();
    build_image(1'b0, 1'b1, 64'd0);
    send_image();

    // Small NAND geometry: end priorities and header fault priorities.
    configure(1'b0, 2, 1, 1, 2, 9);
    build_image(1'b0, 1'b0, 64'd0);
    send_image();
    build_image(1'b1, 1'b0, 64'd0);
    send_image();
    build_image(1'b1, 1'b0, 64'h1);
    send_image();
    build_image(1'b1, 1'b1, 64'd0);
    send_image();
    // A hash mismatch outranks a bad mark, which outranks trailing bytes.
    build_image(1'b1, 1'b1, 64'h8000_0000_0000_0000);
    send_image();
    build_image(1'b0, 1'b1, 64'd0);
    image_q.push_back(8'h00);
    send_image();
    // Without the hash flag the bytes after the payload are trailing bytes.
    build_image(1'b0, 1'b0, 64'd0);
    repeat (2) image_q.push_back(8'($urandom));
    send_image();
    build_image(1'b0, 1'b0, 64'd0);
    image_q[0] ^= 8'hff;
    send_image();
    build_image(1'b0, 1'b0, 64'd0);
    image_q[4] = 8'h02;
    image_q[8] ^= 8'h01;
    send_image();
    // Reserved word fault arrives after a geometry fault and still wins.
    build_image(1'b0, 1'b0, 64'd0);
    image_q[8]  ^= 8'h01;
    image_q[31] = 8'h01;
    send_image();
    build_image(1'b0, 1'b0, 64'd0);
    image_q[20] ^= 8'h01;
    send_image();
    build_image(1'b1, 1'b0, 64'd0);
    image_q[24] |= 8'h04;
    send_image();
    // Truncation inside the trailer, the payload and a faulty header.
    build_image(1'b1, 1'b0, 64'd0);
    repeat (3) void'(image_q.pop_back());
    send_image();
    build_image(1'b0, 1'b0, 64'd0);
    repeat (4) void'(image_q.pop_back());
    send_image();
    build_image(1'b0, 1'b0, 64'd0);
    image_q[0] ^= 8'h01;
    while (image_q.size() > 10) void'(image_q.pop_back());
    send_image();

    // Random images under a new random setting every three images.
    round = 0;
    while (round < 6) begin
      if (round % 3 == 0) random_setting();
      random_image();
      round++;
    end

    // Last stretch runs without idling on either side.
    settle();
    quiet <= 1'b1;
    random_setting();
    repeat (4) random_image();

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
